FILE: hdl/dme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dme_pkg
// Shared types and constants of the demixed magnitude envelope block.
// ----------------------------------------------------------------------------
package dme_pkg;

  localparam int unsigned SRC_W  = 2;
  localparam int unsigned BIN_W  = 9;
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned MAG_W  = 17;
  localparam int unsigned ENV_W  = 21;
  localparam int unsigned RAD_W  = 34;
  localparam int unsigned REM_W  = 19;
  localparam logic [ENV_W-1:0] ENV_MAX = {ENV_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd4;

  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [BIN_W-1:0] bin;
    logic             start;
    logic             emit;
    logic             add_en;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [MAG_W-1:0] mag;
  } work_t;

endpackage
`default_nettype wire

FILE: hdl/dme_mag.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dme_mag
// Pipelined |W*X| in Q.15: complex multiply, squares, one root bit a stage.
// ----------------------------------------------------------------------------
module dme_mag (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         valid_i,
  input  dme_pkg::tag_t               tag_i,
  input  wire  signed [15:0]          xr_i,
  input  wire  signed [15:0]          xi_i,
  input  wire  signed [15:0]          wr_i,
  input  wire  signed [15:0]          wi_i,
  output logic                        valid_o,
  output dme_pkg::work_t              work_o
);
  import dme_pkg::*;

  localparam int unsigned NSTEP = MAG_W;

  logic                     v1_q, v2_q, v3_q, v4_q;
  tag_t                     t1_q, t2_q, t3_q, t4_q;
  logic signed [31:0]       prr_q, pii_q, pri_q, pir_q;
  logic [31:0]              ar_q, ai_q;
  logic [63:0]              sr_q, si_q;
  logic [RAD_W-1:0]         n_q;
  logic signed [32:0]       yr, yi;
  logic [63:0]              s_sum;

  logic                     sv_q  [NSTEP];
  tag_t                     st_q  [NSTEP];
  logic [RAD_W-1:0]         sn_q  [NSTEP];
  logic [REM_W-1:0]         srem_q[NSTEP];
  logic [MAG_W-1:0]         sroot_q[NSTEP];

  assign yr    = 33'(prr_q) - 33'(pii_q);
  assign yi    = 33'(pri_q) + 33'(pir_q);
  assign s_sum = sr_q + si_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= tag_i;
    prr_q <= wr_i * xr_i;
    pii_q <= wi_i * xi_i;
    pri_q <= wr_i * xi_i;
    pir_q <= wi_i * xr_i;
    t2_q  <= t1_q;
    ar_q  <= yr[32] ? 32'(-yr) : 32'(yr);
    ai_q  <= yi[32] ? 32'(-yi) : 32'(yi);
    t3_q  <= t2_q;
    sr_q  <= ar_q * ar_q;
    si_q  <= ai_q * ai_q;
    t4_q  <= t3_q;
    n_q   <= RAD_W'(s_sum >> 30);
  end

  // one root bit per stage, two radicand bits brought down each time
  for (genvar g = 0; g < NSTEP; g++) begin : g_root
    logic [RAD_W-1:0] n_in;
    logic [REM_W-1:0] rem_in, rem_sh, trial;
    logic [MAG_W-1:0] root_in;
    logic             v_in;
    tag_t             t_in;

    if (g == 0) begin : g_first
      assign v_in    = v4_q;
      assign t_in    = t4_q;
      assign n_in    = n_q;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = sv_q[g-1];
      assign t_in    = st_q[g-1];
      assign n_in    = sn_q[g-1];
      assign rem_in  = srem_q[g-1];
      assign root_in = sroot_q[g-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], n_in[RAD_W-1 -: 2]};
    assign trial  = {root_in[REM_W-3:0], 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[g] <= 1'b0;
      end else begin
        sv_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[g] <= t_in;
      sn_q[g] <= {n_in[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        srem_q[g]  <= rem_sh - trial;
        sroot_q[g] <= {root_in[MAG_W-2:0], 1'b1};
      end else begin
        srem_q[g]  <= rem_sh;
        sroot_q[g] <= {root_in[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign valid_o    = sv_q[NSTEP-1];
  assign work_o.tag = st_q[NSTEP-1];
  assign work_o.mag = st_q[NSTEP-1].add_en ? sroot_q[NSTEP-1] : '0;

endmodule
`default_nettype wire

FILE: hdl/dme_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dme_front
// Takes requests, classifies them, holds the channel count and the credit
// counter, and feeds the magnitude pipeline.
// ----------------------------------------------------------------------------
module dme_front #(
  parameter int unsigned QDEPTH = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  [1:0]                  source_index_i,
  input  wire  [8:0]                  bin_index_i,
  input  wire  [3:0]                  channel_index_i,
  input  wire  signed [15:0]          x_real_i,
  input  wire  signed [15:0]          x_imag_i,
  input  wire  signed [15:0]          w_real_i,
  input  wire  signed [15:0]          w_imag_i,
  input  wire                         channel_enabled_i,
  input  wire                         source_active_i,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [4:0]                  cfg_data_i,
  input  wire                         pop_i,
  output logic                        valid_o,
  output dme_pkg::work_t              work_o
);
  import dme_pkg::*;

  localparam int unsigned CR_W = $clog2(QDEPTH + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CR_W-1:0]  cred_q, cred_d;
  logic [CNT_W-1:0] last_chan;
  logic             acc;
  tag_t             tag;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = cred_q < CR_W'(QDEPTH);
  assign acc         = in_valid_i && in_ready_o;
  assign last_chan   = cnt_q - CNT_W'(1);

  assign tag.src    = source_index_i;
  assign tag.bin    = bin_index_i;
  assign tag.start  = channel_index_i == '0;
  assign tag.emit   = {1'b0, channel_index_i} == last_chan;
  assign tag.add_en = channel_enabled_i && source_active_i;

  always_comb begin
    cnt_d  = cfg_valid_i ? cfg_data_i : cnt_q;
    cred_d = cred_q + CR_W'(acc) - CR_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CNT_RESET;
      cred_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      cred_q <= cred_d;
    end
  end

  dme_mag u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .tag_i   (tag),
    .xr_i    (x_real_i),
    .xi_i    (x_imag_i),
    .wr_i    (w_real_i),
    .wi_i    (w_imag_i),
    .valid_o (valid_o),
    .work_o  (work_o)
  );

endmodule
`default_nettype wire

FILE: hdl/dme_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dme_queue
// Work queue between front and back; overflow is ruled out by the credits.
// ----------------------------------------------------------------------------
module dme_queue #(
  parameter int unsigned QDEPTH = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push_i,
  input  dme_pkg::work_t              work_i,
  input  wire                         pop_i,
  output logic                        empty_o,
  output dme_pkg::work_t              head_o
);
  import dme_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QDEPTH + 1);

  work_t              mem_q [QDEPTH];
  logic [PTR_W-1:0]   wp_q, rp_q;
  logic [CNT_QW-1:0]  fill_q;

  assign empty_o = fill_q == '0;
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PTR_W'(QDEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
      end
      if (pop_i) begin
        rp_q <= (rp_q == PTR_W'(QDEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
      end
      fill_q <= fill_q + CNT_QW'(push_i) - CNT_QW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= work_i;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/dme_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dme_back
// Accumulates magnitudes into the per-source, per-bin sums and emits the
// finished envelope; forwards the last write over the read-to-write gap.
// ----------------------------------------------------------------------------
module dme_back #(
  parameter int unsigned MAX_SOURCES = 4,
  parameter int unsigned BINS        = 512
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         empty_i,
  input  dme_pkg::work_t              head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [1:0]                  out_source_o,
  output logic [8:0]                  out_bin_o,
  output logic [20:0]                 envelope_o
);
  import dme_pkg::*;

  localparam int unsigned DEPTH = MAX_SOURCES * BINS;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ENV_W-1:0] sums [DEPTH];
  logic             en;
  logic             b_v_q;
  work_t            b_q;
  logic [ENV_W-1:0] rd_q;
  logic             lw_v_q;
  logic [IDX_W-1:0] lw_idx_q;
  logic [ENV_W-1:0] lw_sum_q;
  logic             ov_q;
  logic [SRC_W-1:0] os_q;
  logic [BIN_W-1:0] ob_q;
  logic [ENV_W-1:0] oe_q;
  logic [IDX_W-1:0] head_idx, b_idx;
  logic             b_keep;
  logic [ENV_W-1:0] base;
  logic [ENV_W:0]   sum_w;
  logic [ENV_W-1:0] sum;
  logic             wr;

  function automatic logic [IDX_W-1:0] to_idx(logic [SRC_W-1:0] s, logic [BIN_W-1:0] b);
    to_idx = IDX_W'(32'(s) * BINS + 32'(b));
  endfunction

  assign en       = !ov_q || out_ready_i;
  assign pop_o    = en && !empty_i;
  assign head_idx = to_idx(head_i.tag.src, head_i.tag.bin);
  assign b_idx    = to_idx(b_q.tag.src, b_q.tag.bin);
  assign b_keep   = (32'(b_q.tag.src) < MAX_SOURCES) && (32'(b_q.tag.bin) < BINS);

  always_comb begin
    if (b_q.tag.start) begin
      base = '0;
    end else if (lw_v_q && lw_idx_q == b_idx) begin
      base = lw_sum_q;
    end else begin
      base = rd_q;
    end
    sum_w = {1'b0, base} + (ENV_W + 1)'(b_q.mag);
    sum   = sum_w[ENV_W] ? ENV_MAX : sum_w[ENV_W-1:0];
    wr    = en && b_v_q && b_keep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q  <= 1'b0;
      lw_v_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (en) begin
        b_v_q <= pop_o;
        ov_q  <= wr && b_q.tag.emit;
      end
      if (wr) begin
        lw_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_q <= head_i;
    end
    if (wr) begin
      lw_idx_q <= b_idx;
      lw_sum_q <= sum;
    end
    if (en) begin
      os_q <= b_q.tag.src;
      ob_q <= b_q.tag.bin;
      oe_q <= sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      sums[b_idx] <= sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q <= sums[head_idx];
    end
  end

  assign out_valid_o  = ov_q;
  assign out_source_o = os_q;
  assign out_bin_o    = ob_q;
  assign envelope_o   = oe_q;

endmodule
`default_nettype wire

FILE: hdl/demixed_magnitude_envelope.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// demixed_magnitude_envelope
// Sums |W*X| over microphone channels per source and bin, emits the envelope.
// ----------------------------------------------------------------------------
// Takes one request per cycle while in_ready_o is high and gives one envelope
// per cycle when the output side is ready. On its way a request passes four
// multiply stages, seventeen square-root stages (one root bit each), the work
// queue and one accumulate stage with its output register. Up to QDEPTH
// requests may be in flight; in_ready_o drops only when the output has been
// stalled long enough to fill them. Channel 0 starts a sum, the channel equal
// to channel_count-1 emits it; a sum must be started before later channels
// add into it. channel_count may be written only while the block is idle.
module demixed_magnitude_envelope #(
  parameter int unsigned MAX_SOURCES  = 4,
  parameter int unsigned BINS         = 512,
  parameter int unsigned QDEPTH       = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  [1:0]                  source_index_i,
  input  wire  [8:0]                  bin_index_i,
  input  wire  [3:0]                  channel_index_i,
  input  wire  signed [15:0]          x_real_i,
  input  wire  signed [15:0]          x_imag_i,
  input  wire  signed [15:0]          w_real_i,
  input  wire  signed [15:0]          w_imag_i,
  input  wire                         channel_enabled_i,
  input  wire                         source_active_i,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [4:0]                  cfg_data_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [1:0]                  out_source_o,
  output logic [8:0]                  out_bin_o,
  output logic [20:0]                 envelope_o
);
  import dme_pkg::*;

  logic  push, pop, empty;
  work_t work, head;

  dme_front #(.QDEPTH(QDEPTH)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .source_index_i    (source_index_i),
    .bin_index_i       (bin_index_i),
    .channel_index_i   (channel_index_i),
    .x_real_i          (x_real_i),
    .x_imag_i          (x_imag_i),
    .w_real_i          (w_real_i),
    .w_imag_i          (w_imag_i),
    .channel_enabled_i (channel_enabled_i),
    .source_active_i   (source_active_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .pop_i             (pop),
    .valid_o           (push),
    .work_o            (work)
  );

  dme_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .work_i  (work),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  dme_back #(.MAX_SOURCES(MAX_SOURCES), .BINS(BINS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_source_o (out_source_o),
    .out_bin_o    (out_bin_o),
    .envelope_o   (envelope_o)
  );

endmodule
`default_nettype wire

FILE: tb/sv/demixed_magnitude_envelope_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demixed_magnitude_envelope_test
// Drives spectrum requests with random gaps and output stalls, predicts each
// envelope from its own magnitude and per-source, per-bin sums, and compares
// every envelope field by field in arrival order.
// ----------------------------------------------------------------------------
module demixed_magnitude_envelope_test;
  import dme_pkg::*;

  localparam int unsigned NSRC  = 4;
  localparam int unsigned NBIN  = 512;
  localparam int unsigned DRAIN = 60;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [BIN_W-1:0] bin;
    logic [ENV_W-1:0] env;
  } env_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        src_d = '0;
  logic [8:0]        bin_d = '0;
  logic [3:0]        chan_d = '0;
  logic signed [15:0] xr_d = '0, xi_d = '0, wr_d = '0, wi_d = '0;
  logic              en_d = 1'b0, act_d = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [4:0]        cfg_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_src;
  logic [8:0]        out_bin;
  logic [20:0]       out_env;

  env_item_t   envelope_queue[$];
  logic [ENV_W-1:0] sums_model[NSRC*NBIN];
  logic [CNT_W-1:0] chan_count_model;
  int          error_count = 0;
  int          env_seen = 0;
  int          req_sent = 0;
  longint unsigned cycle_count = 0;
  bit          hold_off = 1'b0;
  bit          rx_gaps = 1'b1;

  always #1 clk = ~clk;

  demixed_magnitude_envelope DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .source_index_i(src_d), .bin_index_i(bin_d), .channel_index_i(chan_d),
    .x_real_i(xr_d), .x_imag_i(xi_d), .w_real_i(wr_d), .w_imag_i(wi_d),
    .channel_enabled_i(en_d), .source_active_i(act_d),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_source_o(out_src), .out_bin_o(out_bin), .envelope_o(out_env)
  );

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned mag_of_product(logic signed [15:0] xr,
      logic signed [15:0] xi, logic signed [15:0] wr, logic signed [15:0] wi);
    longint yr, yi;
    longint unsigned ar, ai;
    yr = longint'(wr) * longint'(xr) - longint'(wi) * longint'(xi);
    yi = longint'(wr) * longint'(xi) + longint'(wi) * longint'(xr);
    ar = (yr < 0) ? -yr : yr;
    ai = (yi < 0) ? -yi : yi;
    return int_sqrt((ar * ar + ai * ai) >> 30);
  endfunction

  function automatic void predict_envelope(logic [1:0] s, logic [8:0] b, logic [3:0] c,
      logic signed [15:0] xr, logic signed [15:0] xi, logic signed [15:0] wr,
      logic signed [15:0] wi, logic en, logic act);
    longint unsigned sum;
    int idx;
    env_item_t e;
    idx = s * NBIN + b;
    sum = (c == 0) ? 0 : sums_model[idx];
    if (en && act) sum += mag_of_product(xr, xi, wr, wi);
    if (sum > ENV_MAX) sum = ENV_MAX;
    sums_model[idx] = sum[ENV_W-1:0];
    if ({1'b0, c} == chan_count_model - 5'd1) begin
      e.src = s;
      e.bin = b;
      e.env = sum[ENV_W-1:0];
      envelope_queue.push_back(e);
    end
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 30))
                                       : int'($urandom_range(0, 2));
  endfunction

  task automatic send_request(logic [1:0] s, logic [8:0] b, logic [3:0] c,
      logic signed [15:0] xr, logic signed [15:0] xi, logic signed [15:0] wr,
      logic signed [15:0] wi, logic en, logic act, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    src_d <= s; bin_d <= b; chan_d <= c;
    xr_d <= xr; xi_d <= xi; wr_d <= wr; wi_d <= wi;
    en_d <= en; act_d <= act;
    do @(posedge clk); while (!in_ready);
    predict_envelope(s, b, c, xr, xi, wr, wi, en, act);
    req_sent++;
  endtask

  // one full bin sum over channels 0..n-1, channels beyond 15 not sent
  task automatic send_bin(logic [1:0] s, logic [8:0] b, int n, bit gaps, bit extreme);
    logic signed [15:0] v[4];
    for (int c = 0; c < n && c < 16; c++) begin
      foreach (v[k]) v[k] = extreme ? (($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff)
                                    : 16'($urandom());
      send_request(s, b, c[3:0], v[0], v[1], v[2], v[3],
                   $urandom_range(0, 5) != 0, $urandom_range(0, 7) != 0,
                   gaps ? gap_len() : 0);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (envelope_queue.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_channel_count(logic [4:0] n);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chan_count_model = n;
  endtask

  task automatic test_extremes();
    send_request(2'd0, 9'd0, 4'd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 1'b1, 1'b1, 0);
    send_request(2'd0, 9'd0, 4'd1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                 1'b1, 1'b1, 0);
    send_request(2'd0, 9'd0, 4'd2, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                 1'b1, 1'b1, 0);
    send_request(2'd0, 9'd0, 4'd3, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                 1'b1, 1'b1, 0);
    send_request(2'd3, 9'd511, 4'd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 1'b0, 1'b1, 0);
    send_request(2'd3, 9'd511, 4'd1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 1'b1, 1'b0, 0);
    send_request(2'd3, 9'd511, 4'd2, 16'sh0001, 16'shffff, 16'shffff, 16'sh0001,
                 1'b1, 1'b1, 0);
    send_request(2'd3, 9'd511, 4'd3, 16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
                 1'b1, 1'b1, 0);
    send_request(2'd2, 9'd256, 4'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                 1'b1, 1'b1, 0);
    send_request(2'd2, 9'd256, 4'd3, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                 1'b1, 1'b1, 0);
  endtask

  task automatic test_channel_counts();
    write_channel_count(5'd1);
    for (int i = 0; i < 6; i++) send_bin(2'($urandom()), 9'($urandom()), 1, 1'b1, i < 2);
    write_channel_count(5'd16);
    for (int i = 0; i < 4; i++) send_bin(2'($urandom()), 9'($urandom()), 16, 1'b1, i < 3);
    // sums still update with no emit
    write_channel_count(5'd0);
    send_bin(2'd1, 9'd7, 16, 1'b1, 1'b0);
    write_channel_count(5'd17);
    send_bin(2'd1, 9'd8, 16, 1'b1, 1'b0);
    write_channel_count(5'd31);
    send_bin(2'd1, 9'd9, 4, 1'b1, 1'b0);
  endtask

  task automatic test_random();
    int n;
    logic [4:0] counts[4] = '{5'd2, 5'd3, 5'd4, 5'd8};
    for (int phase = 0; phase < 4; phase++) begin
      write_channel_count(counts[phase]);
      n = int'(counts[phase]);
      for (int i = 0; i < 80 / n + 6; i++) begin
        if ($urandom_range(0, 9) == 0)
          // sum over a random count of channels, 1..n, on a random bin
          send_bin(2'($urandom()), 9'($urandom()), int'($urandom_range(1, n)), 1'b1, 1'b0);
        else
          send_bin(2'($urandom()), 9'($urandom()), n, $urandom_range(0, 3) != 0,
                   $urandom_range(0, 15) == 0);
      end
    end
  endtask

  task automatic test_backpressure();
    write_channel_count(5'd2);
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) send_bin(2'($urandom()), 9'($urandom()), 2, 1'b0, 1'b0);
    wait_idle();
    for (int i = 0; i < 20; i++) send_bin(2'($urandom()), 9'($urandom()), 2, 1'b0, 1'b1);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("demixed_magnitude_envelope_test: done, errors");
      $finish;
    end
  end

  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        stall = gap_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    env_item_t e;
    if (rst_n && out_valid && out_ready) begin
      env_seen++;
      if (envelope_queue.size() == 0) begin
        $error("unexpected envelope src=%0d bin=%0d env=%0d", out_src, out_bin, out_env);
        error_count++;
      end else begin
        e = envelope_queue.pop_front();
        if (out_src !== e.src) begin
          $error("out_source expected %0d actual %0d", e.src, out_src);
          error_count++;
        end
        if (out_bin !== e.bin) begin
          $error("out_bin expected %0d actual %0d", e.bin, out_bin);
          error_count++;
        end
        if (out_env !== e.env) begin
          $error("envelope expected %0d actual %0d", e.env, out_env);
          error_count++;
        end
      end
    end
  end

  initial begin
    foreach (sums_model[i]) sums_model[i] = '0;
    chan_count_model = CNT_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_channel_counts();
    test_random();
    test_backpressure();
    wait_idle();
    $display("requests sent: %0d, envelopes checked: %0d", req_sent, env_seen);
    $display("covered channel counts 0,1,2,3,4,8,16,17,31, extremes and output stalls");
    if (error_count == 0 && envelope_queue.size() == 0) begin
      $display("demixed_magnitude_envelope_test: done, clean");
    end else begin
      $display("demixed_magnitude_envelope_test: done, errors");
    end
    $finish;
  end

endmodule
